@@ design/bod_pkg.sv @@
package bod_pkg;

   localparam int LINE_WIDTH  = 1280;
   localparam int STORE_DEPTH = LINE_WIDTH / 4;
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   localparam int COORD_W = 16;
   localparam int PIX_W   = 32;
   localparam int SMALL_W = 24;
   localparam int BAND_W  = COORD_W + 2;
   localparam int CSR_IW  = 3;

   localparam logic [CSR_IW-1:0] CSR_BOX_LEFT     = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_BOX_TOP      = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_BOX_RIGHT    = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_BOX_BOTTOM   = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_BORDER_WIDTH = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_BOX_COLOR    = 3'd5;

   typedef logic [STORE_AW-1:0] store_addr_type;

   typedef struct packed {
      logic                 en;
      store_addr_type       idx;
      store_addr_type       nxt;
      logic [SMALL_W-1:0]   wdata;
   } store_op_type;

endpackage

@@ design/bod_if.sv @@
interface bod_req_if;
   import bod_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIX_W-1:0]   pixel_in;
   logic               frame_start;
   logic               line_end;

   modport source (output valid, pixel_in, frame_start, line_end, input ready);
   modport sink   (input valid, pixel_in, frame_start, line_end, output ready);
endinterface

interface bod_rsp_if;
   import bod_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIX_W-1:0]   full_pixel;
   logic               small_valid;
   logic [SMALL_W-1:0] small_pixel;
   logic               frame_start_out;
   logic               line_end_out;

   modport source (output valid, full_pixel, small_valid, small_pixel, frame_start_out,
                   line_end_out, input ready);
   modport sink   (input valid, full_pixel, small_valid, small_pixel, frame_start_out,
                   line_end_out, output ready);
endinterface

interface bod_csr_if;
   import bod_pkg::*;
   logic               valid;
   logic               ready;
   logic [CSR_IW-1:0]  index;
   logic [PIX_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ design/bod_line_store.sv @@
module bod_line_store (
   input  logic                        clock,
   input  logic                        reset,
   input  bod_pkg::store_op_type       op,
   output logic [bod_pkg::SMALL_W-1:0] run_sum,
   output logic                        busy
);
   import bod_pkg::*;

   logic [SMALL_W-1:0] mem [STORE_DEPTH];
   logic               clr_ff;
   store_addr_type     clr_addr_ff;
   logic [SMALL_W-1:0] rd_ff;
   logic               wr_en;
   store_addr_type     wr_addr;
   logic [SMALL_W-1:0] wr_data;

   always_comb begin
      wr_en   = clr_ff || op.en;
      wr_addr = clr_ff ? clr_addr_ff : op.idx;
      wr_data = clr_ff ? '0 : op.wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         if (clr_addr_ff == STORE_AW'(STORE_DEPTH - 1)) begin
            clr_ff <= 1'b0;
         end
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
      end else if (op.en) begin
         if (op.nxt == op.idx) begin
            rd_ff <= op.wdata;
         end else begin
            rd_ff <= mem[op.nxt];
         end
      end
   end

   assign run_sum = rd_ff;
   assign busy    = clr_ff;

endmodule

@@ design/box_overlay_and_downscale_unit.sv @@
// A result passes the stage one, two, three and last-stage registers in turn.
// Throughput: one request per cycle unless the receiver or the store clear stalls;
// the last stage reads and writes the column-sum store once per fourth column, and
// stalls reach req_chan.ready combinationally. Reset clears the counters, registers
// and pipeline, then zeroes all STORE_DEPTH (320) entries with req_chan.ready low.
module box_overlay_and_downscale_unit (
   input  logic       clock,
   input  logic       reset,
   bod_req_if.sink    req_chan,
   bod_rsp_if.source  rsp_chan,
   bod_csr_if.sink    csr_chan
);
   import bod_pkg::*;

   function automatic logic [7:0] blend_chan(input logic [7:0] p, input logic [7:0] c,
                                             input logic [7:0] a);
      logic [15:0] acc;
      acc = 16'((8'hFF - a) * p) + 16'(a * c);
      return acc[15:8];
   endfunction

   logic [COORD_W-1:0] box_left_ff, box_top_ff, box_right_ff, box_bottom_ff, border_ff;
   logic [PIX_W-1:0]   box_color_ff;
   logic signed [BAND_W-1:0] left_lo_ff, right_hi_ff, top_lo_ff, bottom_hi_ff;

   logic [COORD_W-1:0] x_ff, y_ff, x_in, y_in, x_eff, y_eff;
   store_addr_type     grp_ff, grp_in, grp_eff;

   logic               s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic               adv1, adv2, adv3, adv_out, accept;

   logic [PIX_W-1:0]   s1_pix_ff;
   logic [COORD_W-1:0] s1_x_ff, s1_y_ff;
   store_addr_type     s1_idx_ff;
   logic               s1_fs_ff, s1_le_ff;

   logic [PIX_W-1:0]   s2_pix_ff;
   logic               s2_band_ff, s2_col3_ff, s2_row3_ff, s2_fs_ff, s2_le_ff;
   store_addr_type     s2_idx_ff, s2_nxt_ff;

   logic [PIX_W-1:0]   s3_pix_ff;
   logic               s3_col3_ff, s3_row3_ff, s3_fs_ff, s3_le_ff;
   store_addr_type     s3_idx_ff, s3_nxt_ff;

   logic [PIX_W-1:0]   out_pix_ff;
   logic [SMALL_W-1:0] out_small_ff;
   logic               out_sv_ff, out_fs_ff, out_le_ff;

   logic signed [BAND_W-1:0] xs, ys, ls, rs, ts, bs;
   logic               rows_all, cols_in, band;
   logic [7:0]         blend_a;
   logic [PIX_W-1:0]   blended;
   logic [SMALL_W-1:0] quarter, sum, run_sum;
   store_op_type       op;
   logic               busy;

   // Configuration registers and the band limits derived from them.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_left_ff   <= '0;
         box_top_ff    <= '0;
         box_right_ff  <= '0;
         box_bottom_ff <= '0;
         border_ff     <= '0;
         box_color_ff  <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_BOX_LEFT:     box_left_ff   <= csr_chan.data[COORD_W-1:0];
            CSR_BOX_TOP:      box_top_ff    <= csr_chan.data[COORD_W-1:0];
            CSR_BOX_RIGHT:    box_right_ff  <= csr_chan.data[COORD_W-1:0];
            CSR_BOX_BOTTOM:   box_bottom_ff <= csr_chan.data[COORD_W-1:0];
            CSR_BORDER_WIDTH: border_ff     <= csr_chan.data[COORD_W-1:0];
            CSR_BOX_COLOR:    box_color_ff  <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_lo_ff   <= '0;
         right_hi_ff  <= '0;
         top_lo_ff    <= '0;
         bottom_hi_ff <= '0;
      end else begin
         left_lo_ff   <= $signed({2'b00, box_left_ff})   - $signed({2'b00, border_ff});
         right_hi_ff  <= $signed({2'b00, box_right_ff})  + $signed({2'b00, border_ff});
         top_lo_ff    <= $signed({2'b00, box_top_ff})    - $signed({2'b00, border_ff});
         bottom_hi_ff <= $signed({2'b00, box_bottom_ff}) + $signed({2'b00, border_ff});
      end
   end

   // Pipeline flow control.
   always_comb begin
      adv_out = !out_v_ff || rsp_chan.ready;
      adv3    = !s3_v_ff || adv_out;
      adv2    = !s2_v_ff || adv3;
      adv1    = !s1_v_ff || adv2;
   end

   assign req_chan.ready = adv1 && !busy;
   assign accept         = req_chan.valid && req_chan.ready;

   // Column, row and store-index tracking.
   always_comb begin
      x_eff   = req_chan.frame_start ? '0 : x_ff;
      y_eff   = req_chan.frame_start ? '0 : y_ff;
      grp_eff = req_chan.frame_start ? '0 : grp_ff;
      if (req_chan.line_end) begin
         x_in   = '0;
         y_in   = y_eff + 1'b1;
         grp_in = '0;
      end else begin
         x_in   = x_eff + 1'b1;
         y_in   = y_eff;
         grp_in = grp_eff;
         if (x_eff[1:0] == 2'b11) begin
            if (x_eff == '1 || grp_eff == STORE_AW'(STORE_DEPTH - 1)) begin
               grp_in = '0;
            end else begin
               grp_in = grp_eff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff   <= '0;
         y_ff   <= '0;
         grp_ff <= '0;
      end else if (accept) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         grp_ff <= grp_in;
      end
   end

   // Stage one: the request with its coordinates.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv1) begin
         s1_v_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_pix_ff <= req_chan.pixel_in;
         s1_x_ff   <= x_eff;
         s1_y_ff   <= y_eff;
         s1_idx_ff <= grp_eff;
         s1_fs_ff  <= req_chan.frame_start;
         s1_le_ff  <= req_chan.line_end;
      end
   end

   // Stage two: border band test.
   always_comb begin
      xs = $signed({2'b00, s1_x_ff});
      ys = $signed({2'b00, s1_y_ff});
      ls = $signed({2'b00, box_left_ff});
      rs = $signed({2'b00, box_right_ff});
      ts = $signed({2'b00, box_top_ff});
      bs = $signed({2'b00, box_bottom_ff});
      rows_all = (ys >= top_lo_ff) && (ys <= bottom_hi_ff);
      cols_in  = (xs >= ls) && (xs <= rs);
      band = ((xs >= left_lo_ff) && (xs < ls) && rows_all)
          || ((xs > rs) && (xs <= right_hi_ff) && rows_all)
          || (cols_in && (ys > bs) && (ys <= bottom_hi_ff))
          || (cols_in && (ys >= top_lo_ff) && (ys < ts));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv2) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_pix_ff  <= s1_pix_ff;
         s2_band_ff <= band;
         s2_col3_ff <= (s1_x_ff[1:0] == 2'b11);
         s2_row3_ff <= (s1_y_ff[1:0] == 2'b11);
         s2_idx_ff  <= s1_idx_ff;
         s2_nxt_ff  <= (s1_idx_ff == STORE_AW'(STORE_DEPTH - 1)) ? '0 : s1_idx_ff + 1'b1;
         s2_fs_ff   <= s1_fs_ff;
         s2_le_ff   <= s1_le_ff;
      end
   end

   // Stage three: alpha blend on the band.
   always_comb begin
      blend_a = box_color_ff[31:24];
      blended = {8'h00,
                 blend_chan(s2_pix_ff[23:16], box_color_ff[23:16], blend_a),
                 blend_chan(s2_pix_ff[15:8],  box_color_ff[15:8],  blend_a),
                 blend_chan(s2_pix_ff[7:0],   box_color_ff[7:0],   blend_a)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv3) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_pix_ff  <= s2_band_ff ? blended : s2_pix_ff;
         s3_col3_ff <= s2_col3_ff;
         s3_row3_ff <= s2_row3_ff;
         s3_idx_ff  <= s2_idx_ff;
         s3_nxt_ff  <= s2_nxt_ff;
         s3_fs_ff   <= s2_fs_ff;
         s3_le_ff   <= s2_le_ff;
      end
   end

   // Last stage: accumulate into the column-sum store and register the result.
   always_comb begin
      quarter  = {2'b00, s3_pix_ff[23:18], 2'b00, s3_pix_ff[15:10], 2'b00, s3_pix_ff[7:2]};
      sum      = run_sum + quarter;
      op.en    = adv_out && s3_v_ff && s3_col3_ff;
      op.idx   = s3_idx_ff;
      op.nxt   = s3_nxt_ff;
      op.wdata = s3_row3_ff ? '0 : sum;
   end

   bod_line_store u_store (
      .clock   (clock),
      .reset   (reset),
      .op      (op),
      .run_sum (run_sum),
      .busy    (busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv_out) begin
         out_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out) begin
         out_pix_ff   <= s3_pix_ff;
         out_sv_ff    <= s3_col3_ff;
         out_small_ff <= (s3_col3_ff && s3_row3_ff) ? sum : '0;
         out_fs_ff    <= s3_fs_ff;
         out_le_ff    <= s3_le_ff;
      end
   end

   assign rsp_chan.valid           = out_v_ff;
   assign rsp_chan.full_pixel      = out_pix_ff;
   assign rsp_chan.small_valid     = out_sv_ff;
   assign rsp_chan.small_pixel     = out_small_ff;
   assign rsp_chan.frame_start_out = out_fs_ff;
   assign rsp_chan.line_end_out    = out_le_ff;

endmodule

@@ bench/bod_checker.sv @@
`timescale 1ns / 1ps

module bod_checker
   import bod_pkg::*;
(
   input  logic clock,
   input  logic reset,
   bod_req_if   req_mon,
   bod_rsp_if   rsp_mon,
   bod_csr_if   csr_mon,
   output int   failures,
   output int   outstanding,
   output int   border_hits,
   output int   averages_out
);

   typedef struct packed {
      logic [PIX_W-1:0]   full_pixel;
      logic               small_valid;
      logic [SMALL_W-1:0] small_pixel;
      logic               frame_start_out;
      logic               line_end_out;
   } overlay_out_type;

   logic [COORD_W-1:0] box_left, box_top, box_right, box_bottom, border_width;
   logic [PIX_W-1:0]   box_color;
   logic [COORD_W-1:0] col, row;
   logic [SMALL_W-1:0] column_total [STORE_DEPTH];
   logic [SMALL_W-1:0] carried_total;
   overlay_out_type    awaited_q [$];
   overlay_out_type    got, want;
   int                 results_seen;

   function automatic logic on_border(int x, int y);
      int   l, t, r, b, s;
      logic rows_all, cols_in;
      l = box_left;
      t = box_top;
      r = box_right;
      b = box_bottom;
      s = border_width;
      rows_all = (y >= t - s) && (y <= b + s);
      cols_in  = (x >= l) && (x <= r);
      return (x >= l - s && x < l && rows_all) || (x > r && x <= r + s && rows_all) ||
             (cols_in && y > b && y <= b + s) || (cols_in && y >= t - s && y < t);
   endfunction

   function automatic logic [7:0] blend_byte(logic [7:0] p, logic [7:0] c, logic [7:0] a);
      int pi, ci, ai, mix;
      pi  = p;
      ci  = c;
      ai  = a;
      mix = (255 - ai) * pi + ai * ci;
      return mix[15:8];
   endfunction

   // Computes the expected result of one request and advances the coordinate counters and the column store by it.
   function automatic overlay_out_type overlay_step(logic [PIX_W-1:0] pix_in, logic fs,
                                                    logic le);
      overlay_out_type    res;
      logic [PIX_W-1:0]   pix;
      logic [SMALL_W-1:0] quarter, total;
      int                 slot, next_slot;
      res = '0;
      pix = pix_in;
      if (fs) begin
         col = '0;
         row = '0;
      end
      if (on_border(col, row)) begin
         pix = {8'h00,
                blend_byte(pix[23:16], box_color[23:16], box_color[31:24]),
                blend_byte(pix[15:8], box_color[15:8], box_color[31:24]),
                blend_byte(pix[7:0], box_color[7:0], box_color[31:24])};
         border_hits++;
      end
      if (col[1:0] == 2'b11) begin
         slot      = col >> 2;
         slot      = slot % STORE_DEPTH;
         next_slot = (slot + 1) % STORE_DEPTH;
         quarter   = {2'b00, pix[23:18], 2'b00, pix[15:10], 2'b00, pix[7:2]};
         total     = carried_total + quarter;
         res.small_valid = 1'b1;
         if (row[1:0] == 2'b11) begin
            res.small_pixel    = total;
            column_total[slot] = '0;
            averages_out++;
         end else begin
            column_total[slot] = total;
         end
         carried_total = column_total[next_slot];
      end
      if (le) begin
         col = '0;
         row = row + 1'b1;
      end else begin
         col = col + 1'b1;
      end
      res.full_pixel      = pix;
      res.frame_start_out = fs;
      res.line_end_out    = le;
      return res;
   endfunction

   task automatic note_failure(string what);
      failures++;
      if (failures <= 10) begin
         $display("bod_checker: %s at result %0d", what, results_seen);
         $display("   expected pixel %08h small_valid %0b small %06h fs %0b le %0b",
                  want.full_pixel, want.small_valid, want.small_pixel,
                  want.frame_start_out, want.line_end_out);
         $display("   actual   pixel %08h small_valid %0b small %06h fs %0b le %0b",
                  got.full_pixel, got.small_valid, got.small_pixel,
                  got.frame_start_out, got.line_end_out);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         box_left      = '0;
         box_top       = '0;
         box_right     = '0;
         box_bottom    = '0;
         border_width  = '0;
         box_color     = '0;
         col           = '0;
         row           = '0;
         carried_total = '0;
         for (int i = 0; i < STORE_DEPTH; i++) column_total[i] = '0;
         awaited_q.delete();
         failures      = 0;
         border_hits   = 0;
         averages_out  = 0;
         results_seen  = 0;
         want          = '0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_BOX_LEFT:     box_left     = csr_mon.data[COORD_W-1:0];
               CSR_BOX_TOP:      box_top      = csr_mon.data[COORD_W-1:0];
               CSR_BOX_RIGHT:    box_right    = csr_mon.data[COORD_W-1:0];
               CSR_BOX_BOTTOM:   box_bottom   = csr_mon.data[COORD_W-1:0];
               CSR_BORDER_WIDTH: border_width = csr_mon.data[COORD_W-1:0];
               CSR_BOX_COLOR:    box_color    = csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            awaited_q.push_back(overlay_step(req_mon.pixel_in, req_mon.frame_start,
                                             req_mon.line_end));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.full_pixel      = rsp_mon.full_pixel;
            got.small_valid     = rsp_mon.small_valid;
            got.small_pixel     = rsp_mon.small_pixel;
            got.frame_start_out = rsp_mon.frame_start_out;
            got.line_end_out    = rsp_mon.line_end_out;
            if (awaited_q.size() == 0) begin
               want = '0;
               note_failure("result with no request waiting");
            end else begin
               want = awaited_q.pop_front();
               if (got.full_pixel !== want.full_pixel ||
                   got.small_valid !== want.small_valid ||
                   got.small_pixel !== want.small_pixel ||
                   got.frame_start_out !== want.frame_start_out ||
                   got.line_end_out !== want.line_end_out)
                  note_failure("mismatch");
            end
            results_seen++;
         end
      end
      outstanding = awaited_q.size();
   end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import bod_pkg::*;

   localparam int CYCLE_LIMIT = 900000;
   localparam int RANDOM_REQUESTS = 900;
   localparam logic [CSR_IW-1:0] CSR_SPARE = 3'd7;

   logic clock;
   logic reset;
   int   failures, outstanding, border_hits, averages_out;
   int   cycle_count = 0;
   int   requests_sent = 0;
   int   phases = 0;
   int   directed_count;
   int   rx_stall;
   int   rx_hold = 0;
   logic tx_free = 1'b0;
   logic rx_free = 1'b0;

   bod_req_if req_chan ();
   bod_rsp_if rsp_chan ();
   bod_csr_if csr_chan ();

   box_overlay_and_downscale_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   bod_checker overlay_monitor (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .csr_mon      (csr_chan),
      .failures     (failures),
      .outstanding  (outstanding),
      .border_hits  (border_hits),
      .averages_out (averages_out)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // The request valid is left high on return so that back-to-back requests need no gap.
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs, input logic le);
      int gap;
      gap = tx_free ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid       = 1'b1;
      req_chan.pixel_in    = pix;
      req_chan.frame_start = fs;
      req_chan.line_end    = le;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic drain_results();
      req_chan.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IW-1:0] idx, input logic [PIX_W-1:0] value);
      csr_chan.valid = 1'b1;
      csr_chan.index = idx;
      csr_chan.data  = value;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   task automatic program_box(input logic [15:0] l, input logic [15:0] t, input logic [15:0] r,
                              input logic [15:0] b, input logic [15:0] s,
                              input logic [PIX_W-1:0] colour);
      drain_results();
      write_reg(CSR_BOX_LEFT, {16'($urandom), l});
      write_reg(CSR_BOX_TOP, {16'($urandom), t});
      write_reg(CSR_BOX_RIGHT, {16'($urandom), r});
      write_reg(CSR_BOX_BOTTOM, {16'($urandom), b});
      write_reg(CSR_BORDER_WIDTH, {16'($urandom), s});
      write_reg(CSR_BOX_COLOR, colour);
   endtask

   function automatic logic [15:0] pick_coord(int span);
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, span));
      endcase
   endfunction

   function automatic logic [15:0] pick_band();
      case ($urandom_range(0, 9))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h8000;
         default: return 16'($urandom_range(1, 4));
      endcase
   endfunction

   function automatic logic [PIX_W-1:0] pick_colour();
      logic [7:0] alpha;
      case ($urandom_range(0, 3))
         0:       alpha = 8'h00;
         1:       alpha = 8'hFF;
         default: alpha = 8'($urandom);
      endcase
      return {alpha, 24'($urandom)};
   endfunction

   task automatic send_frame(input int width, input int height);
      for (int r = 0; r < height; r++)
         for (int c = 0; c < width; c++)
            send_pixel($urandom, (r == 0) && (c == 0), c == width - 1);
   endtask

   task automatic send_noise(input int count);
      for (int i = 0; i < count; i++)
         send_pixel($urandom, $urandom_range(0, 9) == 0, $urandom_range(0, 5) == 0);
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         rx_stall = rx_free ? 0 : $urandom_range(0, 16);
         if (rx_hold > 0) begin
            rx_stall = rx_hold;
            rx_hold  = 0;
         end
         if (rx_stall > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (rx_stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.pixel_in    = '0;
      req_chan.frame_start = 1'b0;
      req_chan.line_end    = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.index       = CSR_BOX_LEFT;
      csr_chan.data        = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // A four by four frame around a two by two box with a one-pixel border,
      // with saturated and empty pixels, then single-pixel frames and lines.
      write_reg(CSR_SPARE, 32'hFFFF_FFFF);
      program_box(16'd1, 16'd1, 16'd2, 16'd2, 16'd1, 32'h80C0_40FF);
      for (int i = 0; i < 16; i++)
         send_pixel(i[0] ? 32'hFFFF_FFFF : 32'h0000_0000, i == 0, i[1:0] == 2'b11);
      send_pixel(32'hFFFF_FFFF, 1'b1, 1'b1);
      send_pixel(32'h0000_0000, 1'b0, 1'b1);
      send_pixel(32'hFFFF_FFFF, 1'b1, 1'b0);
      send_pixel(32'h0102_0304, 1'b0, 1'b0);
      directed_count = requests_sent;

      // The receiver holds off while the sender keeps offering requests.
      drain_results();
      tx_free = 1'b1;
      rx_hold = 300;
      send_frame(16, 8);

      while (requests_sent < directed_count + RANDOM_REQUESTS) begin
         program_box(pick_coord(24), pick_coord(12), pick_coord(24), pick_coord(12),
                     pick_band(), pick_colour());
         tx_free = ($urandom_range(0, 3) == 0);
         rx_free = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) != 0)
            send_frame($urandom_range(1, 20), $urandom_range(1, 9));
         else
            send_noise($urandom_range(5, 60));
         phases++;
      end

      drain_results();
      repeat (8) @(negedge clock);
      $display("Covered %0d requests over %0d random box settings, with a long output stall.",
               requests_sent, phases);
      $display("Border pixels blended: %0d, downscaled averages emitted: %0d.",
               border_hits, averages_out);
      if (failures == 0 && outstanding == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

@@ box_overlay_and_downscale_unit.f @@
design/bod_pkg.sv
design/bod_if.sv
design/bod_line_store.sv
design/box_overlay_and_downscale_unit.sv
bench/bod_checker.sv
bench/tb_top.sv
